FILE: hw/rtl/tno_pkg.sv
// ----------------------------------------------------------------------------
// Triangle normal offset package
// Shared item types, widths and pipeline depths for the normal offset pipeline.
// ----------------------------------------------------------------------------
package tno_pkg;

  localparam int COORD_W = 32;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int NORM_W  = 30;
  localparam int SQ_W    = 2 * NORM_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = 31;
  localparam int REM_W   = ROOT_W + 3;
  localparam int QUOT_W  = 31;
  localparam int DREM_W  = 31;

  localparam int NORM_STAGES = 7;
  localparam int FRONT_LAT   = 6 + NORM_STAGES;
  localparam int SQRT_STEPS  = ROOT_W;
  localparam int DIV_STEPS   = QUOT_W;
  localparam int BACK_LAT    = 3;
  localparam int TOTAL_LAT   = FRONT_LAT + SQRT_STEPS + DIV_STEPS + BACK_LAT;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tno_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] moved_a_x;
    logic signed [COORD_W-1:0] moved_a_y;
    logic signed [COORD_W-1:0] moved_a_z;
    logic signed [COORD_W-1:0] moved_b_x;
    logic signed [COORD_W-1:0] moved_b_y;
    logic signed [COORD_W-1:0] moved_b_z;
    logic signed [COORD_W-1:0] moved_c_x;
    logic signed [COORD_W-1:0] moved_c_y;
    logic signed [COORD_W-1:0] moved_c_z;
    logic                      degenerate;
    logic                      saturated;
  } tno_out_t;

  // Data that rides along with an item through the root and divide stages.
  typedef struct packed {
    tno_in_t                item;
    logic                   degen;
    logic [2:0]             neg;
    logic [2:0][NORM_W-1:0] nm;
  } tno_side_t;

endpackage

FILE: hw/rtl/triangle_normal_offset_unit.sv
// ----------------------------------------------------------------------------
// Triangle normal offset unit
// Moves the three vertices of a triangle along its unit normal.
// ----------------------------------------------------------------------------
// An item is one triangle of three signed Q16.16 vertices on in_item; it is
// taken at a clock edge with start high and busy low. busy is high only while
// reset is held, so a new triangle can enter in every cycle.
// Each result appears on out_item for one cycle with out_valid high, in the
// order in which the items were taken. The depth is set by the square
// root and divide pipelines, 31 stages each, one result bit per stage, plus
// 13 front stages (cross product and normalization) and 3 back stages.
// Throughput is one triangle per cycle.
// The offset length is written through cfg_we and cfg_wdata; the user must
// write it only while no item is in flight, as the block does not enforce
// this. Reset clears the pipeline valid bits and sets the offset length to
// zero. The receiver cannot stall: results must be taken when shown.
// ----------------------------------------------------------------------------
module triangle_normal_offset_unit import tno_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tno_in_t            in_item,
  output logic               out_valid,
  output tno_out_t           out_item,
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_wdata
);

  logic signed [COORD_W-1:0] offset_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_length_r <= '0;
    end else if (cfg_we) begin
      offset_length_r <= cfg_wdata;
    end
  end

  assign busy = ~rst_n;

  logic                   fr_valid;
  logic [SUM_W-1:0]       fr_sum;
  tno_side_t              fr_side;
  logic                   sq_valid;
  logic [ROOT_W-1:0]      sq_root;
  tno_side_t              sq_side;
  logic                   dv_valid;
  logic [2:0][QUOT_W-1:0] dv_unit;
  tno_side_t              dv_side;

  tno_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_item   (in_item),
    .out_valid (fr_valid),
    .out_sum   (fr_sum),
    .out_side  (fr_side)
  );

  tno_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_sum    (fr_sum),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  tno_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_mag    (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_unit  (dv_unit),
    .out_side  (dv_side)
  );

  tno_offset u_offset (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (dv_valid),
    .in_unit       (dv_unit),
    .in_side       (dv_side),
    .offset_length (offset_length_r),
    .out_valid     (out_valid),
    .out_item      (out_item)
  );

endmodule

FILE: hw/rtl/tno_front.sv
// ----------------------------------------------------------------------------
// Triangle normal offset front end
// Edge vectors, exact cross product, magnitude and common normalization,
// then the sum of squares of the normalized components.
// ----------------------------------------------------------------------------
module tno_front import tno_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  tno_in_t          in_item,
  output logic             out_valid,
  output logic [SUM_W-1:0] out_sum,
  output tno_side_t        out_side
);

  function automatic logic signed [EDGE_W-1:0] edge_sub(logic signed [COORD_W-1:0] hi_v,
                                                        logic signed [COORD_W-1:0] lo_v);
    return EDGE_W'(hi_v) - EDGE_W'(lo_v);
  endfunction

  // Stage 1: edges.
  logic                     s1_v_r;
  tno_in_t                  s1_item_r;
  logic signed [EDGE_W-1:0] vx_r, vy_r, vz_r, wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    s1_item_r <= in_item;
    vx_r <= edge_sub(in_item.b_x, in_item.a_x);
    vy_r <= edge_sub(in_item.b_y, in_item.a_y);
    vz_r <= edge_sub(in_item.b_z, in_item.a_z);
    wx_r <= edge_sub(in_item.c_x, in_item.b_x);
    wy_r <= edge_sub(in_item.c_y, in_item.b_y);
    wz_r <= edge_sub(in_item.c_z, in_item.b_z);
  end

  // Stage 2: the six partial products.
  logic                     s2_v_r;
  tno_in_t                  s2_item_r;
  logic signed [PROD_W-1:0] p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    s2_item_r <= s1_item_r;
    p_r[0] <= vy_r * wz_r;
    p_r[1] <= vz_r * wy_r;
    p_r[2] <= vz_r * wx_r;
    p_r[3] <= vx_r * wz_r;
    p_r[4] <= vx_r * wy_r;
    p_r[5] <= vy_r * wx_r;
  end

  // Stage 3: cross product components.
  logic                      s3_v_r;
  tno_in_t                   s3_item_r;
  logic signed [CROSS_W-1:0] n_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    s3_item_r <= s2_item_r;
    for (int i = 0; i < 3; i++) begin
      n_r[i] <= CROSS_W'(p_r[2*i]) - CROSS_W'(p_r[2*i+1]);
    end
  end

  // Stage 4: magnitudes, signs and the zero normal check.
  logic [CROSS_W-1:0] abs_w [3];
  logic [MAG_W-1:0]   any_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_w[i] = n_r[i][CROSS_W-1] ? CROSS_W'(-n_r[i]) : CROSS_W'(n_r[i]);
    end
    any_w = abs_w[0][MAG_W-1:0] | abs_w[1][MAG_W-1:0] | abs_w[2][MAG_W-1:0];
  end

  logic             s4_v_r;
  tno_side_t        s4_side_r;
  logic [MAG_W-1:0] s4_mag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else s4_v_r <= s3_v_r;
  end

  always_ff @(posedge clk) begin
    s4_side_r.item  <= s3_item_r;
    s4_side_r.degen <= (any_w == '0);
    s4_side_r.nm    <= '0;
    for (int i = 0; i < 3; i++) begin
      s4_side_r.neg[i] <= n_r[i][CROSS_W-1];
      s4_mag_r[i]      <= abs_w[i][MAG_W-1:0];
    end
  end

  // Stages 5 to 11: binary normalization, all three components by one shift,
  // until the largest of them has its top bit set.
  logic             nr_v_r    [NORM_STAGES];
  tno_side_t        nr_side_r [NORM_STAGES];
  logic [MAG_W-1:0] nr_mag_r  [NORM_STAGES][3];

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam int SH = 64 >> k;
    logic             cur_v;
    tno_side_t        cur_side;
    logic [MAG_W-1:0] cur_mag [3];
    logic [MAG_W-1:0] cur_any;
    logic             do_shift;

    if (k == 0) begin : g_src
      assign cur_v    = s4_v_r;
      assign cur_side = s4_side_r;
      assign cur_mag  = s4_mag_r;
    end else begin : g_src
      assign cur_v    = nr_v_r[k-1];
      assign cur_side = nr_side_r[k-1];
      assign cur_mag  = nr_mag_r[k-1];
    end

    assign cur_any  = cur_mag[0] | cur_mag[1] | cur_mag[2];
    assign do_shift = (cur_any[MAG_W-1 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (!rst_n) nr_v_r[k] <= 1'b0;
      else nr_v_r[k] <= cur_v;
    end

    always_ff @(posedge clk) begin
      nr_side_r[k] <= cur_side;
      for (int i = 0; i < 3; i++) begin
        nr_mag_r[k][i] <= do_shift ? (cur_mag[i] << SH) : cur_mag[i];
      end
    end
  end

  // Stage 12: the top bits are the rescaled components; square them.
  logic              s12_v_r;
  tno_side_t         s12_side_r;
  logic [SQ_W-1:0]   sq_r [3];
  logic [NORM_W-1:0] nm_w [3];
  tno_side_t         side12_w;

  always_comb begin
    side12_w = nr_side_r[NORM_STAGES-1];
    for (int i = 0; i < 3; i++) begin
      nm_w[i]        = nr_mag_r[NORM_STAGES-1][i][MAG_W-1 -: NORM_W];
      side12_w.nm[i] = nm_w[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s12_v_r <= 1'b0;
    else s12_v_r <= nr_v_r[NORM_STAGES-1];
  end

  always_ff @(posedge clk) begin
    s12_side_r <= side12_w;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= nm_w[i] * nm_w[i];
    end
  end

  // Stage 13: sum of squares.
  logic             s13_v_r;
  logic [SUM_W-1:0] s13_sum_r;
  tno_side_t        s13_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s13_v_r <= 1'b0;
    else s13_v_r <= s12_v_r;
  end

  always_ff @(posedge clk) begin
    s13_sum_r  <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    s13_side_r <= s12_side_r;
  end

  assign out_valid = s13_v_r;
  assign out_sum   = s13_sum_r;
  assign out_side  = s13_side_r;

endmodule

FILE: hw/rtl/tno_sqrt.sv
// ----------------------------------------------------------------------------
// Triangle normal offset square root
// Pipelined floor integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tno_sqrt import tno_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  tno_side_t         in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output tno_side_t         out_side
);

  logic              vld_r  [SQRT_STEPS];
  logic [SUM_W-1:0]  rad_r  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_r  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_r [SQRT_STEPS];
  tno_side_t         side_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic              cur_v;
    logic [SUM_W-1:0]  cur_rad;
    logic [REM_W-1:0]  cur_rem;
    logic [ROOT_W-1:0] cur_root;
    tno_side_t         cur_side;
    logic [REM_W-1:0]  acc;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_src
      assign cur_v    = in_valid;
      assign cur_rad  = in_sum;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = in_side;
    end else begin : g_src
      assign cur_v    = vld_r[k-1];
      assign cur_rad  = rad_r[k-1];
      assign cur_rem  = rem_r[k-1];
      assign cur_root = root_r[k-1];
      assign cur_side = side_r[k-1];
    end

    // The partial remainder never exceeds twice the partial root.
    assign acc   = {cur_rem[REM_W-3:0], cur_rad[SUM_W-1 -: 2]};
    assign trial = REM_W'({cur_root, 2'b01});
    assign take  = (acc >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else vld_r[k] <= cur_v;
    end

    always_ff @(posedge clk) begin
      rad_r[k]  <= cur_rad << 2;
      rem_r[k]  <= take ? (acc - trial) : acc;
      root_r[k] <= {cur_root[ROOT_W-2:0], take};
      side_r[k] <= cur_side;
    end
  end

  assign out_valid = vld_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

FILE: hw/rtl/tno_div.sv
// ----------------------------------------------------------------------------
// Triangle normal offset divider
// Three pipelined restoring dividers sharing one divisor: each forms the
// rounded unit normal component (n * 2^30 + mag / 2) / mag, one bit a stage.
// ----------------------------------------------------------------------------
module tno_div import tno_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [ROOT_W-1:0]      in_mag,
  input  tno_side_t              in_side,
  output logic                   out_valid,
  output logic [2:0][QUOT_W-1:0] out_unit,
  output tno_side_t              out_side
);

  logic              vld_r  [DIV_STEPS];
  logic [ROOT_W-1:0] mag_r  [DIV_STEPS];
  tno_side_t         side_r [DIV_STEPS];
  logic [DREM_W-1:0] rem_r  [DIV_STEPS][3];
  logic [DREM_W-1:0] bits_r [DIV_STEPS][3];
  logic [QUOT_W-1:0] q_r    [DIV_STEPS][3];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic              cur_v;
    logic [ROOT_W-1:0] cur_mag;
    tno_side_t         cur_side;
    logic [DREM_W-1:0] cur_rem  [3];
    logic [DREM_W-1:0] cur_bits [3];
    logic [QUOT_W-1:0] cur_q    [3];

    if (k == 0) begin : g_src
      // The dividend is {n, mag[30:1]}; its top bits start as the remainder.
      assign cur_v    = in_valid;
      assign cur_mag  = in_mag;
      assign cur_side = in_side;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign cur_rem[i]  = DREM_W'(in_side.nm[i][NORM_W-1:1]);
        assign cur_bits[i] = {in_side.nm[i][0], in_mag[ROOT_W-1:1]};
        assign cur_q[i]    = '0;
      end
    end else begin : g_src
      assign cur_v    = vld_r[k-1];
      assign cur_mag  = mag_r[k-1];
      assign cur_side = side_r[k-1];
      assign cur_rem  = rem_r[k-1];
      assign cur_bits = bits_r[k-1];
      assign cur_q    = q_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else vld_r[k] <= cur_v;
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane_step
      logic [DREM_W:0] trial;
      logic            take;

      assign trial = {cur_rem[i], cur_bits[i][DREM_W-1]};
      assign take  = (trial >= {1'b0, cur_mag});

      always_ff @(posedge clk) begin
        rem_r[k][i]  <= take ? DREM_W'(trial - {1'b0, cur_mag}) : trial[DREM_W-1:0];
        bits_r[k][i] <= cur_bits[i] << 1;
        q_r[k][i]    <= {cur_q[i][QUOT_W-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      mag_r[k]  <= cur_mag;
      side_r[k] <= cur_side;
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_unit[i] = q_r[DIV_STEPS-1][i];
    end
  end

endmodule

FILE: hw/rtl/tno_offset.sv
// ----------------------------------------------------------------------------
// Triangle normal offset back end
// Scales the unit normal by the offset length, rounds to Q16.16 and adds the
// result to every vertex with saturation.
// ----------------------------------------------------------------------------
module tno_offset import tno_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [2:0][QUOT_W-1:0]    in_unit,
  input  tno_side_t                 in_side,
  input  logic signed [COORD_W-1:0] offset_length,
  output logic                      out_valid,
  output tno_out_t                  out_item
);

  localparam int PRD_W = QUOT_W + COORD_W;
  localparam int RND_W = PRD_W - 30;
  localparam int DST_W = RND_W + 1;
  localparam int ACC_W = DST_W + 1;

  // Stage 1: magnitude products and their signs.
  logic [COORD_W-1:0] off_mag_w;
  logic               s1_v_r;
  tno_side_t          s1_side_r;
  logic [PRD_W-1:0]   prod_r [3];
  logic [2:0]         s1_neg_r;

  assign off_mag_w = offset_length[COORD_W-1] ? COORD_W'(-offset_length)
                                              : COORD_W'(offset_length);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    s1_side_r <= in_side;
    for (int i = 0; i < 3; i++) begin
      prod_r[i]   <= PRD_W'(in_unit[i]) * PRD_W'(off_mag_w);
      s1_neg_r[i] <= in_side.neg[i] ^ offset_length[COORD_W-1];
    end
  end

  // Stage 2: round half away from zero and apply the sign; a zero normal gives zero.
  logic                    s2_v_r;
  tno_side_t               s2_side_r;
  logic signed [DST_W-1:0] dist_r [3];
  logic [PRD_W-1:0]        rnd_w  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_w[i] = prod_r[i] + PRD_W'(1 << 29);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    s2_side_r <= s1_side_r;
    for (int i = 0; i < 3; i++) begin
      if (s1_side_r.degen) begin
        dist_r[i] <= '0;
      end else if (s1_neg_r[i]) begin
        dist_r[i] <= -DST_W'(rnd_w[i][PRD_W-1:30]);
      end else begin
        dist_r[i] <= DST_W'(rnd_w[i][PRD_W-1:30]);
      end
    end
  end

  // Stage 3: move the nine coordinates and clip.
  logic signed [COORD_W-1:0] crd_w  [9];
  logic signed [COORD_W-1:0] mvd_w  [9];
  logic [8:0]                clip_w;
  logic signed [ACC_W-1:0]   acc_w  [9];

  always_comb begin
    crd_w[0] = s2_side_r.item.a_x;
    crd_w[1] = s2_side_r.item.a_y;
    crd_w[2] = s2_side_r.item.a_z;
    crd_w[3] = s2_side_r.item.b_x;
    crd_w[4] = s2_side_r.item.b_y;
    crd_w[5] = s2_side_r.item.b_z;
    crd_w[6] = s2_side_r.item.c_x;
    crd_w[7] = s2_side_r.item.c_y;
    crd_w[8] = s2_side_r.item.c_z;
    for (int c = 0; c < 9; c++) begin
      acc_w[c] = ACC_W'(crd_w[c]) + ACC_W'(dist_r[c % 3]);
      if (acc_w[c] > $signed(ACC_W'({1'b0, {(COORD_W-1){1'b1}}}))) begin
        mvd_w[c]  = {1'b0, {(COORD_W-1){1'b1}}};
        clip_w[c] = 1'b1;
      end else if (acc_w[c] < -$signed(ACC_W'({1'b1, {(COORD_W-1){1'b0}}}))) begin
        mvd_w[c]  = {1'b1, {(COORD_W-1){1'b0}}};
        clip_w[c] = 1'b1;
      end else begin
        mvd_w[c]  = acc_w[c][COORD_W-1:0];
        clip_w[c] = 1'b0;
      end
    end
  end

  logic     s3_v_r;
  tno_out_t s3_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    s3_item_r.moved_a_x  <= mvd_w[0];
    s3_item_r.moved_a_y  <= mvd_w[1];
    s3_item_r.moved_a_z  <= mvd_w[2];
    s3_item_r.moved_b_x  <= mvd_w[3];
    s3_item_r.moved_b_y  <= mvd_w[4];
    s3_item_r.moved_b_z  <= mvd_w[5];
    s3_item_r.moved_c_x  <= mvd_w[6];
    s3_item_r.moved_c_y  <= mvd_w[7];
    s3_item_r.moved_c_z  <= mvd_w[8];
    s3_item_r.degenerate <= s2_side_r.degen;
    s3_item_r.saturated  <= |clip_w;
  end

  assign out_valid = s3_v_r;
  assign out_item  = s3_item_r;

endmodule

FILE: hw/rtl/tno_checker.sv
// ----------------------------------------------------------------------------
// Triangle normal offset checker
// Port level assertions on busy, latency, zero normal flags and pass-through.
// ----------------------------------------------------------------------------
module tno_checker import tno_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input tno_in_t  in_item,
  input logic     out_valid,
  input tno_out_t out_item
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Every result traces back to an item taken exactly one latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching item");

  a_degen_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |-> !out_item.saturated)
    else $error("degenerate item flagged saturated");

  // A zero normal passes the vertices through unchanged; checked on a_x, b_y, c_z.
  a_degen_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |->
      out_item.moved_a_x == $past(in_item.a_x, TOTAL_LAT) &&
      out_item.moved_b_y == $past(in_item.b_y, TOTAL_LAT) &&
      out_item.moved_c_z == $past(in_item.c_z, TOTAL_LAT))
    else $error("degenerate item not passed through");

endmodule

bind triangle_normal_offset_unit tno_checker u_tno_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
